// ===== rtl/stks_pkg.sv =====
`default_nettype none
// ============================================================================
// stks_pkg: shared codes and types for the sorted table key search block
// Command and search-method codes used by the channel interfaces and the
// search sequencer.
// ============================================================================
package stks_pkg;

    localparam int CMD_W    = 1;
    localparam int METHOD_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [METHOD_W-1:0] method_t;

    localparam cmd_t CMD_WRITE  = 1'b0;
    localparam cmd_t CMD_SEARCH = 1'b1;

    localparam method_t METHOD_LINEAR = 2'd0;
    localparam method_t METHOD_BINARY = 2'd1;
    localparam method_t METHOD_INTERP = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/stks_if.sv =====
`default_nettype none
// ============================================================================
// stks_if: channel interfaces of the sorted table key search block
// The input channel carries write and search commands; the output channel
// carries one search answer per beat.
// ============================================================================
interface stks_in_if import stks_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int KEY_BITS = 16
);
    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [IDX_W-1:0]    entry_index;
    logic [KEY_BITS-1:0] entry_key;
    logic [KEY_BITS-1:0] search_key;
    method_t             method;

    modport source (output valid, cmd, entry_index, entry_key, search_key, method,
                    input ready);
    modport sink   (input valid, cmd, entry_index, entry_key, search_key, method,
                    output ready);
endinterface

interface stks_out_if
#(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
);
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] probe_count;

    modport source (output valid, found, position, probe_count, input ready);
    modport sink   (input valid, found, position, probe_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/sorted_table_key_search.sv =====
`default_nettype none
// ============================================================================
// sorted_table_key_search: key table with linear, binary and interpolation
// search
// A table of TABLE_DEPTH keys is held in a synchronous RAM. Write beats load
// entries; search beats look up a key among the first entry_count entries.
// ============================================================================
// A write beat stores its key and gives no answer; writes at an
// index at or above TABLE_DEPTH are dropped. A search beat gives exactly one
// answer beat with found, position (0 when not found) and the probe count.
// The block works on one search at a time; its pace is set by the single RAM
// read port and, for interpolation, by the multiply-divide unit. A linear
// scan streams one entry per cycle. A binary search reads and then compares
// each probe. An interpolation iteration takes up to two bound reads, a
// check, a multiply and a division, and a probe read and compare. A
// finished answer sits in an output register, so the next beat is taken
// while the previous answer still waits for the sink. Binary and
// interpolation search assume the entries in use ascend; entries never
// written read back as unknown data. The entry_count register may only be
// written while no search is in flight and no answer is pending.
// ============================================================================
module sorted_table_key_search import stks_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]   cfg_wr_data,
    stks_in_if.sink                                 in_ch,
    stks_out_if.source                              out_ch
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LIN       = 4'd1;
    localparam logic [3:0] S_BIN_ISSUE = 4'd2;
    localparam logic [3:0] S_BIN_CMP   = 4'd3;
    localparam logic [3:0] S_INT_CHK   = 4'd4;
    localparam logic [3:0] S_INT_RL    = 4'd5;
    localparam logic [3:0] S_INT_RH    = 4'd6;
    localparam logic [3:0] S_INT_DIV   = 4'd7;
    localparam logic [3:0] S_INT_CMP   = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    // Control registers.
    logic [3:0]          state_reg,       state_next;
    logic [CNT_W-1:0]    entry_count_reg;
    logic                out_valid_reg,   out_valid_next;
    logic                lin_vld_reg,     lin_vld_next;
    logic                tl_ok_reg,       tl_ok_next;
    logic                th_ok_reg,       th_ok_next;

    // Search working registers.
    logic [KEY_BITS-1:0] key_reg,         key_next;
    logic [CNT_W-1:0]    lo_reg,          lo_next;
    logic [CNT_W-1:0]    hi_ex_reg,       hi_ex_next;     // one past the upper bound
    logic [IDX_W-1:0]    mid_reg,         mid_next;       // probe index in flight
    logic [CNT_W-1:0]    lin_addr_reg,    lin_addr_next;  // next entry to read
    logic [KEY_BITS-1:0] tl_reg,          tl_next;        // key at lower bound
    logic [KEY_BITS-1:0] th_reg,          th_next;        // key at upper bound
    logic [CNT_W-1:0]    probes_reg,      probes_next;
    logic                found_reg,       found_next;
    logic [IDX_W-1:0]    pos_reg,         pos_next;

    // Answer register.
    logic                out_found_reg,   out_found_next;
    logic [IDX_W-1:0]    out_pos_reg,     out_pos_next;
    logic [CNT_W-1:0]    out_probes_reg,  out_probes_next;

    // RAM and divider hookup.
    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [IDX_W-1:0]    div_quot;

    // Derived values.
    logic [CNT_W-1:0]    n_eff;
    logic                idx_ok;
    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    bin_mid;
    logic [CNT_W-1:0]    hi_cnt;
    logic [CNT_W-1:0]    int_p;

    // An entry count beyond the depth searches the whole table.
    assign n_eff = (entry_count_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : entry_count_reg;
    assign idx_ok = (CNT_W'(in_ch.entry_index) < CNT_W'(TABLE_DEPTH));

    // Midpoint floor((lo + hi) / 2) with hi = hi_ex - 1; only used when lo < hi_ex.
    assign mid_sum = (CNT_W+1)'(lo_reg) + (CNT_W+1)'(hi_ex_reg) - 1'b1;
    assign bin_mid = IDX_W'(mid_sum >> 1);

    assign hi_cnt = hi_ex_reg - 1'b1;
    assign int_p  = lo_reg + CNT_W'(div_quot);

    assign in_ch.ready = (state_reg == S_IDLE);

    stks_ram
    #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    )
    u_key_table
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_ch.entry_index),
        .wdata (in_ch.entry_key),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The numerator factor key - tl never exceeds th - tl because the check
    // state only starts the unit once tl <= key <= th holds.
    stks_div
    #(
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (key_reg - tl_reg),
        .b     (IDX_W'(hi_cnt - lo_reg)),
        .d     (th_reg - tl_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        lin_vld_next    = lin_vld_reg;
        tl_ok_next      = tl_ok_reg;
        th_ok_next      = th_ok_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_ex_next      = hi_ex_reg;
        mid_next        = mid_reg;
        lin_addr_next   = lin_addr_reg;
        tl_next         = tl_reg;
        th_next         = th_reg;
        probes_next     = probes_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;
        out_probes_next = out_probes_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        div_start       = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.cmd == CMD_WRITE)
                    begin
                        ram_we = idx_ok;
                    end
                    else
                    begin
                        key_next      = in_ch.search_key;
                        probes_next   = '0;
                        found_next    = 1'b0;
                        pos_next      = '0;
                        lo_next       = '0;
                        hi_ex_next    = n_eff;
                        lin_addr_next = '0;
                        lin_vld_next  = 1'b0;
                        tl_ok_next    = 1'b0;
                        th_ok_next    = 1'b0;
                        if (n_eff == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            unique case (in_ch.method)
                                METHOD_LINEAR: state_next = S_LIN;
                                METHOD_BINARY: state_next = S_BIN_ISSUE;
                                METHOD_INTERP: state_next = S_INT_CHK;
                                default:       state_next = S_DONE;
                            endcase
                        end
                    end
                end
            end

            // Reads stream one entry per cycle; the entry read last cycle is
            // compared while the next one is fetched.
            S_LIN:
            begin
                if (lin_vld_reg)
                begin
                    probes_next = probes_reg + 1'b1;
                end
                if (lin_vld_reg && (ram_rdata == key_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = IDX_W'(lin_addr_reg - 1'b1);
                    state_next = S_DONE;
                end
                else if (lin_addr_reg < n_eff)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = IDX_W'(lin_addr_reg);
                    lin_addr_next = lin_addr_reg + 1'b1;
                    lin_vld_next  = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_BIN_ISSUE:
            begin
                if (lo_reg >= hi_ex_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = bin_mid;
                    mid_next   = bin_mid;
                    state_next = S_BIN_CMP;
                end
            end

            S_BIN_CMP:
            begin
                probes_next = probes_reg + 1'b1;
                state_next  = S_BIN_ISSUE;
                if (ram_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                    state_next = S_DONE;
                end
                else if (ram_rdata < key_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + 1'b1;
                end
                else
                begin
                    hi_ex_next = CNT_W'(mid_reg);
                end
            end

            // Bound keys are cached; only a bound that moved is read again.
            S_INT_CHK:
            begin
                if (lo_reg >= hi_ex_reg)
                begin
                    state_next = S_DONE;
                end
                else if (!tl_ok_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(lo_reg);
                    state_next = S_INT_RL;
                end
                else if (!th_ok_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(hi_cnt);
                    state_next = S_INT_RH;
                end
                else if ((key_reg < tl_reg) || (key_reg > th_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    probes_next = probes_reg + 1'b1;
                    if (tl_reg == th_reg)
                    begin
                        // Flat range: the search ends here either way.
                        found_next = (tl_reg == key_reg);
                        pos_next   = (tl_reg == key_reg) ? IDX_W'(lo_reg) : '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_INT_DIV;
                    end
                end
            end

            S_INT_RL:
            begin
                tl_next    = ram_rdata;
                tl_ok_next = 1'b1;
                state_next = S_INT_CHK;
            end

            S_INT_RH:
            begin
                th_next    = ram_rdata;
                th_ok_next = 1'b1;
                state_next = S_INT_CHK;
            end

            S_INT_DIV:
            begin
                if (div_done)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(int_p);
                    mid_next   = IDX_W'(int_p);
                    state_next = S_INT_CMP;
                end
            end

            S_INT_CMP:
            begin
                state_next = S_INT_CHK;
                if (ram_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                    state_next = S_DONE;
                end
                else if (ram_rdata < key_reg)
                begin
                    lo_next    = CNT_W'(mid_reg) + 1'b1;
                    tl_ok_next = 1'b0;
                end
                else
                begin
                    hi_ex_next = CNT_W'(mid_reg);
                    th_ok_next = 1'b0;
                end
            end

            // Hand the answer to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_pos_next    = pos_reg;
                    out_probes_next = probes_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            lin_vld_reg     <= 1'b0;
            tl_ok_reg       <= 1'b0;
            th_ok_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lin_vld_reg   <= lin_vld_next;
            tl_ok_reg     <= tl_ok_next;
            th_ok_reg     <= th_ok_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_ex_reg      <= hi_ex_next;
        mid_reg        <= mid_next;
        lin_addr_reg   <= lin_addr_next;
        tl_reg         <= tl_next;
        th_reg         <= th_next;
        probes_reg     <= probes_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        out_found_reg  <= out_found_next;
        out_pos_reg    <= out_pos_next;
        out_probes_reg <= out_probes_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.found       = out_found_reg;
    assign out_ch.position    = out_pos_reg;
    assign out_ch.probe_count = out_probes_reg;

    // A hit always points inside the entries in use.
    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.found) |-> (CNT_W'(out_ch.position) < n_eff))
        else $error("found position lies outside the entries in use");

    // Every method shrinks its range on each probe, so probes never exceed n.
    a_probes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.probe_count <= n_eff))
        else $error("probe count exceeds the number of entries in use");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_INT_DIV))
        else $error("divider finished outside the interpolation wait state");

    // A divider start always leads into the wait state.
    a_div_start_next: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_INT_DIV))
        else $error("divider started without entering the wait state");

endmodule
`default_nettype wire

// ===== rtl/stks_ram.sv =====
`default_nettype none
// ============================================================================
// stks_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module stks_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/stks_div.sv =====
`default_nettype none
// ============================================================================
// stks_div: interpolation step unit
// Computes floor(a * b / d) for the interpolation probe: a multiply first,
// then one restoring-division step per quotient bit. The caller
// guarantees a <= d and b < 2**IDX_W, so the quotient fits IDX_W bits.
// ============================================================================
module stks_div
#(
    parameter int KEY_BITS = 16,
    parameter int IDX_W    = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [KEY_BITS-1:0] a,
    input  wire logic [IDX_W-1:0]    b,
    input  wire logic [KEY_BITS-1:0] d,
    output      logic                done,
    output      logic [IDX_W-1:0]    quot
);

    localparam int PROD_W = KEY_BITS + IDX_W;
    localparam int STEP_W = $clog2(IDX_W + 1);

    logic                busy_reg;
    logic                mul_pend_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_cnt_reg;
    logic [KEY_BITS-1:0] a_reg;
    logic [IDX_W-1:0]    b_reg;
    logic [KEY_BITS-1:0] d_reg;
    logic [KEY_BITS-1:0] rem_reg;
    logic [IDX_W-1:0]    low_reg;
    logic [IDX_W-1:0]    quot_reg;

    logic [PROD_W-1:0]   prod;
    logic [KEY_BITS:0]   trial;
    logic                q_bit;

    assign prod  = PROD_W'(a_reg) * PROD_W'(b_reg);
    assign trial = {rem_reg, low_reg[IDX_W-1]};
    assign q_bit = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            mul_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
            step_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg     <= 1'b1;
                mul_pend_reg <= 1'b1;
            end
            else if (mul_pend_reg)
            begin
                mul_pend_reg <= 1'b0;
                step_cnt_reg <= STEP_W'(IDX_W);
            end
            else if (busy_reg)
            begin
                step_cnt_reg <= step_cnt_reg - 1'b1;
                if (step_cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            d_reg <= d;
        end
        else if (mul_pend_reg)
        begin
            rem_reg  <= prod[PROD_W-1:IDX_W];
            low_reg  <= prod[IDX_W-1:0];
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= q_bit ? KEY_BITS'(trial - {1'b0, d_reg}) : trial[KEY_BITS-1:0];
            low_reg  <= low_reg << 1;
            quot_reg <= IDX_W'({quot_reg, q_bit});
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire
